/* rtl/tlca_pkg.sv */
// ----------------------------------------------------------------------------
// tlca_pkg: shared types and constants for the tree lca engine
// Field structs, operation codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package tlca_pkg;

	localparam int NODE_W  = 10;
	localparam int STAMP_W = 11;
	localparam int LVL_N   = 11;
	localparam int LVL_W   = 4;
	localparam int OP_W    = 3;

	localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
	localparam logic [OP_W-1:0] OP_ANC  = 3'd1;
	localparam logic [OP_W-1:0] OP_LCA  = 3'd2;
	localparam logic [OP_W-1:0] OP_DIST = 3'd3;
	localparam logic [OP_W-1:0] OP_KTH  = 3'd4;
	localparam logic [OP_W-1:0] OP_PATH = 3'd5;

	localparam logic [NODE_W-1:0] DEPTH_MAX = 10'd1023;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [NODE_W-1:0]  node_a;
		logic [NODE_W-1:0]  node_b;
		logic [NODE_W-1:0]  parent_node;
		logic [STAMP_W-1:0] enter_stamp;
		logic [STAMP_W-1:0] exit_stamp;
		logic [STAMP_W-1:0] step_count;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  result_node;
		logic [STAMP_W-1:0] path_length;
		logic               is_ancestor;
		logic               valid_res;
	} out_item_t;

	// datapath micro-operations
	localparam logic [3:0] DP_NOP      = 4'd0;
	localparam logic [3:0] DP_LATCH    = 4'd1;  // capture input item
	localparam logic [3:0] DP_LD_RD    = 4'd2;  // read parent depth / link
	localparam logic [3:0] DP_LD_WR0   = 4'd3;  // write depth, stamps, level 0
	localparam logic [3:0] DP_LD_RDLV  = 4'd4;  // read link(lvl-1, cur)
	localparam logic [3:0] DP_LD_WRLV  = 4'd5;  // write link(lvl, a), cur <= it
	localparam logic [3:0] DP_RD_AB    = 4'd6;  // read info of a and b
	localparam logic [3:0] DP_CHK_AB   = 4'd7;  // ancestor tests a/b
	localparam logic [3:0] DP_LCA_RD   = 4'd8;  // read link(lvl, a)
	localparam logic [3:0] DP_LCA_INFO = 4'd9;  // read stamps of up
	localparam logic [3:0] DP_LCA_CHK  = 4'd10; // maybe a <= up
	localparam logic [3:0] DP_LCA_FIN  = 4'd11; // read link(0, a)
	localparam logic [3:0] DP_LCA_SET  = 4'd12; // lca <= link, read depth
	localparam logic [3:0] DP_PATH_SET = 4'd13; // compute distance, pick climb
	localparam logic [3:0] DP_CLB_RD   = 4'd14; // read link(lvl, cur)
	localparam logic [3:0] DP_CLB_STEP = 4'd15; // cur <= link if bit set

	typedef struct packed {
		logic [3:0]       op;
		logic [LVL_W-1:0] lvl;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] operation;
	} dp_sts_t;

endpackage

/* rtl/tlca_datapath.sv */
// ----------------------------------------------------------------------------
// tlca_datapath: tables, working registers and arithmetic
// Holds the lift table and node info memories; executes controller commands.
// ----------------------------------------------------------------------------
module tlca_datapath (
	input  logic                clk,
	input  tlca_pkg::in_item_t  in_item,
	input  tlca_pkg::dp_cmd_t   cmd,
	output tlca_pkg::dp_sts_t   sts,
	output tlca_pkg::out_item_t res
);
	import tlca_pkg::*;

	localparam int LIFT_DEPTH = LVL_N * (1 << NODE_W);
	localparam int LIFT_AW    = $clog2(LIFT_DEPTH);

	logic [NODE_W-1:0]  lift_mem [LIFT_DEPTH];
	logic [NODE_W-1:0]  depth_mem [1 << NODE_W];
	logic [STAMP_W-1:0] ent_mem [1 << NODE_W];
	logic [STAMP_W-1:0] ext_mem [1 << NODE_W];

	in_item_t           it_q;
	logic [NODE_W-1:0]  a_q, cur_q, lca_q, lift_rd_q, dep_rd_q;
	logic [STAMP_W-1:0] ent_b_q, ext_b_q, ent_u_q, ext_u_q;
	logic [NODE_W-1:0]  dep_a_q, dep_b_q;
	logic [STAMP_W-1:0] kk_q, total_q;
	logic               a_anc_b_q, b_anc_a_q, bad_q;

	logic [LIFT_AW-1:0] lift_ra, lift_wa;
	logic [NODE_W-1:0]  lift_rnode, info_rnode, dep_wd, lift_wd;
	logic               lift_we;
	logic [NODE_W:0]    dep_inc;
	logic [NODE_W:0]    du, dv;
	logic [STAMP_W:0]   tot;
	logic [STAMP_W-1:0] tot_c;

	always_comb begin
		lift_rnode = cur_q;
		info_rnode = cur_q;
		case (cmd.op)
			DP_LD_RD:    info_rnode = it_q.parent_node;
			DP_RD_AB:    info_rnode = it_q.node_a;
			DP_LCA_RD:   lift_rnode = a_q;
			DP_LCA_INFO: begin
				info_rnode = lift_rd_q;
				lift_rnode = a_q;
			end
			DP_LCA_FIN:  lift_rnode = a_q;
			DP_LCA_SET:  info_rnode = a_anc_b_q ? it_q.node_a :
				(b_anc_a_q ? it_q.node_b : lift_rd_q);
			default: ;
		endcase
	end

	assign lift_ra = LIFT_AW'(cmd.lvl) * LIFT_AW'(1 << NODE_W) + LIFT_AW'(lift_rnode);
	assign lift_wa = LIFT_AW'(cmd.lvl) * LIFT_AW'(1 << NODE_W) + LIFT_AW'(it_q.node_a);
	assign lift_we = (cmd.op == DP_LD_WR0) || (cmd.op == DP_LD_WRLV);
	assign lift_wd = (cmd.op == DP_LD_WR0) ? it_q.parent_node : lift_rd_q;
	assign dep_inc = {1'b0, dep_rd_q} + 1'b1;
	assign dep_wd  = (it_q.node_a == it_q.parent_node) ? '0 :
		(dep_inc > {1'b0, DEPTH_MAX}) ? DEPTH_MAX : dep_inc[NODE_W-1:0];

	always_ff @(posedge clk) begin
		if (lift_we)
			lift_mem[lift_wa] <= lift_wd;
		lift_rd_q <= lift_mem[lift_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_LD_WR0) begin
			depth_mem[it_q.node_a] <= dep_wd;
			ent_mem[it_q.node_a]   <= it_q.enter_stamp;
			ext_mem[it_q.node_a]   <= it_q.exit_stamp;
		end
		dep_rd_q <= depth_mem[info_rnode];
		ent_u_q  <= ent_mem[info_rnode];
		ext_u_q  <= ext_mem[info_rnode];
	end

	// b-side info read through a second port of the small stores
	logic [NODE_W-1:0]  dep_b_rd;
	logic [STAMP_W-1:0] ent_b_rd, ext_b_rd;
	always_ff @(posedge clk) begin
		dep_b_rd <= depth_mem[it_q.node_b];
		ent_b_rd <= ent_mem[it_q.node_b];
		ext_b_rd <= ext_mem[it_q.node_b];
	end

	assign du    = {1'b0, dep_a_q} - {1'b0, dep_rd_q};
	assign dv    = {1'b0, dep_b_q} - {1'b0, dep_rd_q};
	assign tot   = {{(STAMP_W-NODE_W){du[NODE_W]}}, du} + {{(STAMP_W-NODE_W){dv[NODE_W]}}, dv};
	assign tot_c = tot[STAMP_W] ? '0 : tot[STAMP_W-1:0];

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LATCH: it_q <= in_item;
			DP_LD_RD: cur_q <= it_q.node_a;
			DP_LD_WRLV: cur_q <= lift_rd_q;
			DP_LD_WR0: cur_q <= it_q.parent_node;
			DP_CHK_AB: begin
				dep_a_q   <= dep_rd_q;
				ent_b_q   <= ent_b_rd;
				ext_b_q   <= ext_b_rd;
				dep_b_q   <= dep_b_rd;
				a_anc_b_q <= (ent_u_q <= ent_b_rd) && (ext_b_rd <= ext_u_q);
				b_anc_a_q <= (ent_b_rd <= ent_u_q) && (ext_u_q <= ext_b_rd);
				a_q       <= it_q.node_a;
				cur_q     <= it_q.node_a;
				kk_q      <= it_q.step_count;
				bad_q     <= it_q.step_count > {1'b0, dep_rd_q};
			end
			DP_LCA_CHK: begin
				if (!((ent_u_q <= ent_b_q) && (ext_b_q <= ext_u_q)))
					a_q <= lift_rd_q;
			end
			DP_LCA_SET: lca_q <= lift_rd_q;
			DP_PATH_SET: begin
				total_q <= tot_c;
				if (it_q.step_count <= du && !du[NODE_W]) begin
					cur_q <= it_q.node_a;
					kk_q  <= it_q.step_count;
					bad_q <= it_q.step_count > tot_c;
				end else begin
					cur_q <= it_q.node_b;
					kk_q  <= tot_c - it_q.step_count;
					bad_q <= (it_q.step_count > tot_c)
						|| ((tot_c - it_q.step_count) > {1'b0, dep_b_q});
				end
			end
			DP_CLB_STEP: if (kk_q[cmd.lvl]) cur_q <= lift_rd_q;
			default: ;
		endcase
	end

	// lca when one node contains the other, else the climbed result
	logic [NODE_W-1:0] lca_v;
	assign lca_v = a_anc_b_q ? it_q.node_a : (b_anc_a_q ? it_q.node_b : lca_q);

	always_comb begin
		res = '0;
		res.valid_res = 1'b1;
		case (it_q.operation)
			OP_ANC:  res.is_ancestor = a_anc_b_q;
			OP_LCA:  res.result_node = lca_v;
			OP_DIST: res.path_length = total_q;
			OP_KTH, OP_PATH: begin
				res.valid_res   = !bad_q;
				res.result_node = bad_q ? '0 : cur_q;
			end
			default: ;
		endcase
	end

	assign sts.operation = it_q.operation;

endmodule

/* rtl/tlca_ctrl.sv */
// ----------------------------------------------------------------------------
// tlca_ctrl: sequencer for loads and queries
// Steps the datapath through load, lca climb and k-th climb phases.
// ----------------------------------------------------------------------------
module tlca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tlca_pkg::dp_sts_t sts,
	output tlca_pkg::dp_cmd_t cmd,
	output logic              res_load,
	input  logic              res_free
);
	import tlca_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_LDRD  = 4'd2;
	localparam logic [3:0] S_LDWR0 = 4'd3;
	localparam logic [3:0] S_LDRL  = 4'd4;
	localparam logic [3:0] S_LDWL  = 4'd5;
	localparam logic [3:0] S_RDAB  = 4'd6;
	localparam logic [3:0] S_CHK   = 4'd7;
	localparam logic [3:0] S_LRD   = 4'd8;
	localparam logic [3:0] S_LINF  = 4'd9;
	localparam logic [3:0] S_LCHK  = 4'd10;
	localparam logic [3:0] S_LFIN  = 4'd11;
	localparam logic [3:0] S_LSET  = 4'd12;
	localparam logic [3:0] S_PSET  = 4'd13;
	localparam logic [3:0] S_CRD   = 4'd14;
	localparam logic [3:0] S_CSTP  = 4'd15;

	logic [3:0]       state_q, state_d;
	logic [LVL_W-1:0] lvl_q, lvl_d;
	logic             done_q, done_d;

	assign in_stall = (state_q != S_IDLE) || done_q;
	assign res_load = done_q && res_free;

	always_comb begin
		state_d = state_q;
		lvl_d   = lvl_q;
		done_d  = done_q && !res_free;
		cmd.op  = DP_NOP;
		cmd.lvl = lvl_q;
		case (state_q)
			S_IDLE: if (in_valid && !done_q) begin
				cmd.op  = DP_LATCH;
				state_d = S_DEC;
			end
			S_DEC: begin
				lvl_d = '0;
				if (sts.operation == OP_LOAD)
					state_d = S_LDRD;
				else if (sts.operation inside {OP_ANC, OP_LCA, OP_DIST, OP_KTH, OP_PATH})
					state_d = S_RDAB;
				else
					state_d = S_IDLE;
			end
			S_LDRD: begin
				cmd.op  = DP_LD_RD;
				state_d = S_LDWR0;
			end
			S_LDWR0: begin
				cmd.op  = DP_LD_WR0;
				cmd.lvl = '0;
				lvl_d   = LVL_W'(1);
				state_d = S_LDRL;
			end
			S_LDRL: begin
				// cur holds link(lvl-1, a); its own level-(lvl-1) link is link(lvl, a)
				cmd.op  = DP_LD_RDLV;
				cmd.lvl = lvl_q - 1'b1;
				state_d = S_LDWL;
			end
			S_LDWL: begin
				cmd.op = DP_LD_WRLV;
				if (lvl_q == LVL_W'(LVL_N - 1))
					state_d = S_IDLE;
				else begin
					lvl_d   = lvl_q + 1'b1;
					state_d = S_LDRL;
				end
			end
			S_RDAB: begin
				cmd.op  = DP_RD_AB;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.op = DP_CHK_AB;
				lvl_d  = LVL_W'(LVL_N - 1);
				if (sts.operation == OP_ANC || sts.operation == OP_KTH)
					state_d = (sts.operation == OP_ANC) ? S_IDLE : S_CRD;
				else
					state_d = S_LRD;
				if (sts.operation == OP_KTH) lvl_d = '0;
				if (sts.operation == OP_ANC) done_d = 1'b1;
			end
			S_LRD: begin
				cmd.op  = DP_LCA_RD;
				state_d = S_LINF;
			end
			S_LINF: begin
				cmd.op  = DP_LCA_INFO;
				state_d = S_LCHK;
			end
			S_LCHK: begin
				cmd.op = DP_LCA_CHK;
				if (lvl_q == '0)
					state_d = S_LFIN;
				else begin
					lvl_d   = lvl_q - 1'b1;
					state_d = S_LRD;
				end
			end
			S_LFIN: begin
				cmd.op  = DP_LCA_FIN;
				cmd.lvl = '0;
				state_d = S_LSET;
			end
			S_LSET: begin
				cmd.op  = DP_LCA_SET;
				state_d = S_PSET;
			end
			S_PSET: begin
				cmd.op = DP_PATH_SET;
				lvl_d  = '0;
				if (sts.operation == OP_PATH)
					state_d = S_CRD;
				else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			S_CRD: begin
				cmd.op  = DP_CLB_RD;
				state_d = S_CSTP;
			end
			S_CSTP: begin
				cmd.op = DP_CLB_STEP;
				if (lvl_q == LVL_W'(LVL_N - 1)) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					lvl_d   = lvl_q + 1'b1;
					state_d = S_CRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			done_q  <= done_d;
		end
	end

endmodule

/* rtl/tree_lca_binary_lifting_top.sv */
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_top: binary-lifting lca query engine
//
//  channel | signals                        | direction
//  in      | in_valid, in_stall, in_data    | host -> block
//  out     | out_valid, out_stall, out_data | block -> host
//
// Each transaction runs to completion before the next one is accepted. Per level,
// the lca climb steps through a link read, a stamp read and a check; the kth
// and path climbs through a link read and a step; each load level through a
// link read and a write.
// Reset clears only control; tables are undefined until loaded.
// A held result stalls input until taken.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tlca_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tlca_pkg::out_item_t out_data
);
	import tlca_pkg::*;

	dp_cmd_t   cmd;
	dp_sts_t   sts;
	out_item_t res;
	logic      res_load;
	logic      res_free;

	assign res_free = !out_valid || !out_stall;

	tlca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd),
		.res_load (res_load),
		.res_free (res_free)
	);

	tlca_datapath u_dp (
		.clk     (clk),
		.in_item (in_data),
		.cmd     (cmd),
		.sts     (sts),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (res_load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			out_data <= res;
	end

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> out_valid)
		else $error("result load lost");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("stalled result changed");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(in_valid && !in_stall))
		else $error("accept during result load");

endmodule
